>>> rtl/sts_pkg.sv
package sts_pkg;

    localparam int DEF_PLOT_LEFT    = 20;
    localparam int DEF_PLOT_TOP     = 40;
    localparam int DEF_PLOT_COLUMNS = 280;
    localparam int DEF_PLOT_ROWS    = 160;

    localparam int SAMPLE_W = 12;
    localparam int FRAC_W   = 16;
    localparam int SMOOTH_W = SAMPLE_W + FRAC_W;
    localparam int GAIN_W   = 17;
    localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(65536);
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(6554);

    localparam int COLX_W = 9;
    localparam int ROWY_W = 8;

    localparam int TEXT_PERIOD = 12;
    localparam int PHASE_W     = 4;

    // shared multiplier
    localparam int MUL_A_W = 30;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // row scaling: h = ceil(ceil(v*N / 2^28) / 20), the last step by reciprocal
    localparam int ROW_SHIFT   = 28;
    localparam int ROW_DIV     = 20;
    localparam int RECIP_MUL   = 3277;
    localparam int RECIP_SHIFT = 16;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_RANGE  = 2'd1,
        CMD_FILTER = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    localparam logic [1:0] RANGE_LAST = 2'd2;

    typedef enum logic [2:0] {
        OP_ACCEPT,
        OP_PREP,
        OP_MUL_FILT,
        OP_ADD_FILT,
        OP_MUL_ROW,
        OP_CEIL,
        OP_MUL_RECIP,
        OP_FINISH
    } op_t;

    typedef enum logic [1:0] {
        C_NEXT,
        C_IN,
        C_KEY,
        C_OUT
    } cond_t;

    localparam int UPC_W = 3;
    typedef logic [UPC_W-1:0] upc_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  target;
    } uword_t;

    typedef struct packed {
        logic in_valid;
        logic cmd_none;
        logic cmd_key;
        logic out_free;
    } seq_stat_t;

    typedef struct packed {
        op_t  op;
        logic exec;
    } seq_ctrl_t;

    function automatic uword_t ucode_rom(upc_t addr);
        uword_t w;
        unique case (addr)
            3'd0:    w = '{op: OP_ACCEPT,    cond: C_IN,   target: 3'd0};
            3'd1:    w = '{op: OP_PREP,      cond: C_KEY,  target: 3'd4};
            3'd2:    w = '{op: OP_MUL_FILT,  cond: C_NEXT, target: 3'd0};
            3'd3:    w = '{op: OP_ADD_FILT,  cond: C_NEXT, target: 3'd0};
            3'd4:    w = '{op: OP_MUL_ROW,   cond: C_NEXT, target: 3'd0};
            3'd5:    w = '{op: OP_CEIL,      cond: C_NEXT, target: 3'd0};
            3'd6:    w = '{op: OP_MUL_RECIP, cond: C_NEXT, target: 3'd0};
            default: w = '{op: OP_FINISH,    cond: C_OUT,  target: 3'd0};
        endcase
        return w;
    endfunction

    function automatic int range_factor(logic [1:0] r);
        int f;
        unique case (r)
            2'd1:    f = 33;
            2'd2:    f = 66;
            default: f = 20;
        endcase
        return f;
    endfunction

endpackage

>>> rtl/scope_trace_sweep_unit.sv
// one item is in work at a time: a new sample or key is taken only after the last one's
// result is in the output register; samples run the whole 8-step microprogram, keys skip
//   the filter steps; one 30x18 multiplier is shared for filter, row scale and reciprocal
// the next item is taken while a finished result waits in the output register
// reset: synchronous, active low; gain 6554, filter on, range 0, sweep at left edge
module scope_trace_sweep_unit #(
    parameter int PLOT_LEFT    = sts_pkg::DEF_PLOT_LEFT,
    parameter int PLOT_TOP     = sts_pkg::DEF_PLOT_TOP,
    parameter int PLOT_COLUMNS = sts_pkg::DEF_PLOT_COLUMNS,
    parameter int PLOT_ROWS    = sts_pkg::DEF_PLOT_ROWS
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sts_pkg::GAIN_W-1:0]    cfg_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_cmd,
    input  logic [sts_pkg::SAMPLE_W-1:0]  s_sample,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_restart_frame,
    output logic                          m_draw_segment,
    output logic [sts_pkg::COLX_W-1:0]    m_from_x,
    output logic [sts_pkg::ROWY_W-1:0]    m_from_y,
    output logic [sts_pkg::COLX_W-1:0]    m_to_x,
    output logic [sts_pkg::ROWY_W-1:0]    m_to_y,
    output logic [sts_pkg::SAMPLE_W-1:0]  m_shown_value,
    output logic [1:0]                    m_range_now,
    output logic                          m_filter_now,
    output logic                          m_text_refresh
);
    import sts_pkg::*;

    localparam int COL_END  = PLOT_LEFT + PLOT_COLUMNS;
    localparam int COL_W    = $clog2(COL_END + 1);
    localparam int BOTTOM   = PLOT_TOP + PLOT_ROWS;
    localparam int ROW_W    = $clog2(BOTTOM + 1);
    localparam int HGT_W    = $clog2(PLOT_ROWS + 1);
    localparam int N_MAX    = 66 * PLOT_ROWS;
    localparam int Q1_W     = $clog2(N_MAX + 1);
    localparam int SAT_LIM  = ROW_DIV * (PLOT_ROWS - 1);
    localparam logic [PROD_W-1:0] CEIL_ADD = PROD_W'((64'd1 << ROW_SHIFT) - 64'd1);

    seq_stat_t stat;
    seq_ctrl_t ctrl;

    sts_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    logic [GAIN_W-1:0]          gain_reg, gain_next;
    cmd_t                       cmd_reg, cmd_next;
    logic [SAMPLE_W-1:0]        sample_reg, sample_next;
    logic [SMOOTH_W-1:0]        smooth_reg, smooth_next;
    logic                       primed_reg, primed_next;
    logic                       fresh_reg, fresh_next;
    logic [COL_W-1:0]           sweep_reg, sweep_next;
    logic [COL_W-1:0]           prev_col_reg, prev_col_next;
    logic [ROWY_W-1:0]          prev_row_reg, prev_row_next;
    logic [1:0]                 range_reg, range_next;
    logic                       filter_reg, filter_next;
    logic [PHASE_W-1:0]         phase_reg, phase_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic [Q1_W-1:0]            q1_reg, q1_next;
    logic                       sat_reg, sat_next;

    logic                       m_valid_reg, m_valid_next;
    logic                       restart_reg, restart_next;
    logic                       draw_reg, draw_next;
    logic [COLX_W-1:0]          from_x_reg, from_x_next;
    logic [ROWY_W-1:0]          from_y_reg, from_y_next;
    logic [COLX_W-1:0]          to_x_reg, to_x_next;
    logic [ROWY_W-1:0]          to_y_reg, to_y_next;
    logic [SAMPLE_W-1:0]        shown_reg, shown_next;
    logic [1:0]                 range_out_reg, range_out_next;
    logic                       filter_out_reg, filter_out_next;
    logic                       text_reg, text_next;

    logic                       out_free;
    logic                       fire;
    logic [SMOOTH_W-1:0]        samp_q;
    logic [GAIN_W-1:0]          gain_sat;
    logic signed [SMOOTH_W:0]   diff;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   rnd;
    logic signed [PROD_W-1:0]   step_val;
    logic [PROD_W-1:0]          ceil_sum;
    logic [Q1_W:0]              recip_x;
    logic [HGT_W-1:0]           hgt;
    logic [ROW_W-1:0]           row_full;
    logic [ROWY_W-1:0]          row;
    logic                       at_edge;
    logic [COL_W-1:0]           x_to;
    logic [COL_W-1:0]           x_from;

    assign out_free  = !m_valid_reg || m_ready;
    assign fire      = ctrl.exec;
    assign s_ready   = (ctrl.op == OP_ACCEPT);
    assign cfg_ready = 1'b1;

    always_comb begin
        stat.in_valid = s_valid;
        stat.cmd_none = (cmd_t'(s_cmd) == CMD_NONE);
        stat.cmd_key  = (cmd_reg != CMD_SAMPLE);
        stat.out_free = out_free;
    end

    // datapath helpers
    always_comb begin
        samp_q   = {sample_reg, {FRAC_W{1'b0}}};
        gain_sat = (gain_reg > GAIN_ONE) ? GAIN_ONE : gain_reg;
        diff     = $signed({1'b0, samp_q}) - $signed({1'b0, smooth_reg});
        rnd      = prod_reg + PROD_W'(32768);
        step_val = rnd >>> FRAC_W;
        ceil_sum = prod_reg + CEIL_ADD;
        recip_x  = {1'b0, q1_reg} + (Q1_W+1)'(ROW_DIV - 1);
        hgt      = sat_reg ? HGT_W'(PLOT_ROWS) : prod_reg[RECIP_SHIFT +: HGT_W];
        row_full = ROW_W'(BOTTOM) - ROW_W'(hgt);
        row      = ROWY_W'(row_full);
        at_edge  = (sweep_reg >= COL_W'(COL_END));
        x_to     = at_edge ? COL_W'(PLOT_LEFT) : sweep_reg;
        x_from   = at_edge ? COL_W'(PLOT_LEFT) : prev_col_reg;
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.op)
            OP_MUL_FILT: begin
                mul_a = MUL_A_W'(diff);
                mul_b = $signed({1'b0, gain_sat});
            end
            OP_MUL_ROW: begin
                mul_a = $signed({{(MUL_A_W-SMOOTH_W){1'b0}}, smooth_reg});
                mul_b = MUL_B_W'(range_factor(range_reg) * PLOT_ROWS);
            end
            OP_MUL_RECIP: begin
                mul_a = $signed({{(MUL_A_W-Q1_W-1){1'b0}}, recip_x});
                mul_b = MUL_B_W'(RECIP_MUL);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        gain_next       = gain_reg;
        cmd_next        = cmd_reg;
        sample_next     = sample_reg;
        smooth_next     = smooth_reg;
        primed_next     = primed_reg;
        fresh_next      = fresh_reg;
        sweep_next      = sweep_reg;
        prev_col_next   = prev_col_reg;
        prev_row_next   = prev_row_reg;
        range_next      = range_reg;
        filter_next     = filter_reg;
        phase_next      = phase_reg;
        prod_next       = prod_reg;
        q1_next         = q1_reg;
        sat_next        = sat_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        restart_next    = restart_reg;
        draw_next       = draw_reg;
        from_x_next     = from_x_reg;
        from_y_next     = from_y_reg;
        to_x_next       = to_x_reg;
        to_y_next       = to_y_reg;
        shown_next      = shown_reg;
        range_out_next  = range_out_reg;
        filter_out_next = filter_out_reg;
        text_next       = text_reg;

        if (cfg_valid) begin
            gain_next = cfg_data;
        end

        unique case (ctrl.op)
            OP_ACCEPT: begin
                if (fire) begin
                    cmd_next    = cmd_t'(s_cmd);
                    sample_next = s_sample;
                end
            end
            OP_PREP: begin
                fresh_next = 1'b0;
                unique case (cmd_reg)
                    CMD_RANGE: begin
                        range_next = (range_reg == RANGE_LAST) ? 2'd0 : range_reg + 2'd1;
                    end
                    CMD_FILTER: begin
                        filter_next = !filter_reg;
                        smooth_next = samp_q;
                        primed_next = 1'b1;
                    end
                    default: begin
                        if (!primed_reg) begin
                            fresh_next  = 1'b1;
                            smooth_next = samp_q;
                            primed_next = 1'b1;
                        end
                    end
                endcase
            end
            OP_MUL_FILT: begin
                prod_next = mul_a * mul_b;
            end
            OP_ADD_FILT: begin
                smooth_next = filter_reg ? smooth_reg + step_val[SMOOTH_W-1:0] : samp_q;
            end
            OP_MUL_ROW: begin
                prod_next = mul_a * mul_b;
            end
            OP_CEIL: begin
                q1_next  = ceil_sum[ROW_SHIFT +: Q1_W];
                sat_next = (ceil_sum[ROW_SHIFT +: Q1_W] > Q1_W'(SAT_LIM));
            end
            OP_MUL_RECIP: begin
                prod_next = mul_a * mul_b;
            end
            OP_FINISH: begin
                if (fire) begin
                    m_valid_next    = 1'b1;
                    shown_next      = smooth_reg[FRAC_W +: SAMPLE_W];
                    range_out_next  = range_reg;
                    filter_out_next = filter_reg;
                    prev_row_next   = row;
                    priority if (cmd_reg == CMD_SAMPLE) begin
                        restart_next  = at_edge;
                        draw_next     = 1'b1;
                        from_x_next   = COLX_W'(x_from);
                        from_y_next   = (at_edge || fresh_reg) ? row : prev_row_reg;
                        to_x_next     = COLX_W'(x_to);
                        to_y_next     = row;
                        text_next     = (phase_reg == '0);
                        phase_next    = (phase_reg == PHASE_W'(TEXT_PERIOD - 1)) ?
                                        '0 : phase_reg + PHASE_W'(1);
                        prev_col_next = x_to;
                        sweep_next    = x_to + COL_W'(1);
                    end else begin
                        restart_next  = 1'b1;
                        draw_next     = 1'b0;
                        from_x_next   = '0;
                        from_y_next   = '0;
                        to_x_next     = '0;
                        to_y_next     = '0;
                        text_next     = 1'b0;
                        prev_col_next = COL_W'(PLOT_LEFT);
                        sweep_next    = COL_W'(PLOT_LEFT);
                    end
                end
            end
            default: begin
                prod_next = prod_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg     <= GAIN_RESET;
            smooth_reg   <= '0;
            primed_reg   <= 1'b0;
            fresh_reg    <= 1'b0;
            sweep_reg    <= COL_W'(PLOT_LEFT);
            prev_col_reg <= COL_W'(PLOT_LEFT);
            prev_row_reg <= ROWY_W'(BOTTOM);
            range_reg    <= 2'd0;
            filter_reg   <= 1'b1;
            phase_reg    <= '0;
            cmd_reg      <= CMD_SAMPLE;
            m_valid_reg  <= 1'b0;
        end else begin
            gain_reg     <= gain_next;
            smooth_reg   <= smooth_next;
            primed_reg   <= primed_next;
            fresh_reg    <= fresh_next;
            sweep_reg    <= sweep_next;
            prev_col_reg <= prev_col_next;
            prev_row_reg <= prev_row_next;
            range_reg    <= range_next;
            filter_reg   <= filter_next;
            phase_reg    <= phase_next;
            cmd_reg      <= cmd_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload and scratch registers
    always_ff @(posedge aclk) begin
        sample_reg     <= sample_next;
        prod_reg       <= prod_next;
        q1_reg         <= q1_next;
        sat_reg        <= sat_next;
        restart_reg    <= restart_next;
        draw_reg       <= draw_next;
        from_x_reg     <= from_x_next;
        from_y_reg     <= from_y_next;
        to_x_reg       <= to_x_next;
        to_y_reg       <= to_y_next;
        shown_reg      <= shown_next;
        range_out_reg  <= range_out_next;
        filter_out_reg <= filter_out_next;
        text_reg       <= text_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_restart_frame = restart_reg;
    assign m_draw_segment  = draw_reg;
    assign m_from_x        = from_x_reg;
    assign m_from_y        = from_y_reg;
    assign m_to_x          = to_x_reg;
    assign m_to_y          = to_y_reg;
    assign m_shown_value   = shown_reg;
    assign m_range_now     = range_out_reg;
    assign m_filter_now    = filter_out_reg;
    assign m_text_refresh  = text_reg;

endmodule

>>> rtl/sts_useq.sv
module sts_useq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sts_pkg::seq_stat_t    stat,
    output sts_pkg::seq_ctrl_t    ctrl
);
    import sts_pkg::*;

    upc_t   upc_reg;
    upc_t   upc_next;
    upc_t   upc_inc;
    uword_t uw;
    logic   exec;

    assign uw      = ucode_rom(upc_reg);
    assign upc_inc = upc_reg + upc_t'(1);

    always_comb begin
        upc_next = upc_inc;
        exec     = 1'b1;
        unique case (uw.cond)
            C_NEXT: begin
                upc_next = upc_inc;
            end
            C_IN: begin
                exec     = stat.in_valid;
                upc_next = (!stat.in_valid || stat.cmd_none) ? uw.target : upc_inc;
            end
            C_KEY: begin
                upc_next = stat.cmd_key ? uw.target : upc_inc;
            end
            C_OUT: begin
                exec     = stat.out_free;
                upc_next = stat.out_free ? uw.target : upc_reg;
            end
            default: begin
                upc_next = upc_inc;
            end
        endcase
    end

    always_comb begin
        ctrl.op   = uw.op;
        ctrl.exec = exec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= '0;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

>>> rtl/sts_check.sv
module sts_check (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [1:0]                    s_cmd,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_restart_frame,
    input logic                          m_draw_segment,
    input logic [sts_pkg::COLX_W-1:0]    m_from_x,
    input logic [sts_pkg::ROWY_W-1:0]    m_from_y,
    input logic [sts_pkg::COLX_W-1:0]    m_to_x,
    input logic [sts_pkg::ROWY_W-1:0]    m_to_y,
    input logic [sts_pkg::SAMPLE_W-1:0]  m_shown_value,
    input logic [1:0]                    m_range_now,
    input logic                          m_filter_now,
    input logic                          m_text_refresh
);
    import sts_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_restart_frame)
            && $stable(m_draw_segment) && $stable(m_from_x) && $stable(m_from_y)
            && $stable(m_to_x) && $stable(m_to_y) && $stable(m_shown_value)
            && $stable(m_range_now) && $stable(m_filter_now) && $stable(m_text_refresh))
        else $error("result changed while stalled");

    // one item in work at a time, unused commands are dropped at once
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (cmd_t'(s_cmd) != CMD_NONE) |=> !s_ready)
        else $error("input ready right after a transfer");

    // key results restart the frame and carry no segment
    a_key_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_draw_segment |-> m_restart_frame && m_from_x == '0
            && m_from_y == '0 && m_to_x == '0 && m_to_y == '0 && !m_text_refresh)
        else $error("key result fields not cleared");

    a_range_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_range_now != 2'd3)
        else $error("range index out of set");

endmodule

bind scope_trace_sweep_unit sts_check u_sts_check (.*);

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import sts_pkg::*;

    localparam int LEFT_X      = DEF_PLOT_LEFT;
    localparam int TOP_Y       = DEF_PLOT_TOP;
    localparam int RIGHT_X     = DEF_PLOT_LEFT + DEF_PLOT_COLUMNS;
    localparam int ROWS        = DEF_PLOT_ROWS;
    localparam int SETTLE      = 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic                restart;
        logic                draw;
        logic [COLX_W-1:0]   fx;
        logic [ROWY_W-1:0]   fy;
        logic [COLX_W-1:0]   tx;
        logic [ROWY_W-1:0]   ty;
        logic [SAMPLE_W-1:0] shown;
        logic [1:0]          rng;
        logic                filt;
        logic                text;
    } trace_res_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [GAIN_W-1:0] cfg_data  = '0;

    logic                s_valid  = 1'b0;
    logic                s_ready;
    logic [1:0]          s_cmd    = '0;
    logic [SAMPLE_W-1:0] s_sample = '0;

    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_restart_frame;
    logic                m_draw_segment;
    logic [COLX_W-1:0]   m_from_x;
    logic [ROWY_W-1:0]   m_from_y;
    logic [COLX_W-1:0]   m_to_x;
    logic [ROWY_W-1:0]   m_to_y;
    logic [SAMPLE_W-1:0] m_shown_value;
    logic [1:0]          m_range_now;
    logic                m_filter_now;
    logic                m_text_refresh;

    // trace predictor state
    logic [GAIN_W-1:0]   gain_q;
    logic [SMOOTH_W-1:0] smooth_q;
    logic                primed_q;
    logic [COLX_W-1:0]   sweep_col;
    logic [COLX_W-1:0]   last_col;
    logic [ROWY_W-1:0]   last_row;
    logic [1:0]          range_q;
    logic                filter_q;
    logic [PHASE_W-1:0]  text_ph;

    trace_res_t trace_q[$];

    int  err_count  = 0;
    int  res_count  = 0;
    int  cycle_cnt  = 0;
    int  stall_left = 0;
    int  sink_draw;
    bit  src_idle   = 1'b1;
    bit  sink_idle  = 1'b1;

    scope_trace_sweep_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_sample        (s_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_restart_frame (m_restart_frame),
        .m_draw_segment  (m_draw_segment),
        .m_from_x        (m_from_x),
        .m_from_y        (m_from_y),
        .m_to_x          (m_to_x),
        .m_to_y          (m_to_y),
        .m_shown_value   (m_shown_value),
        .m_range_now     (m_range_now),
        .m_filter_now    (m_filter_now),
        .m_text_refresh  (m_text_refresh)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[scope_trace_sweep_unit] ERROR");
            $finish;
        end
    end

    function automatic logic [ROWY_W-1:0] row_for(logic [SMOOTH_W-1:0] v);
        logic [63:0] scale;
        logic [63:0] prod;
        logic [63:0] den;
        logic [63:0] h;
        case (range_q)
            2'd1:    scale = 64'd33 * ROWS;
            2'd2:    scale = 64'd66 * ROWS;
            default: scale = 64'd20 * ROWS;
        endcase
        prod = 64'(v) * scale;
        den  = 64'd20 << 28;
        h    = (prod + den - 64'd1) / den;
        if (h > ROWS)
            h = ROWS;
        return ROWY_W'(TOP_Y + ROWS - h);
    endfunction

    function automatic void reset_trace();
        gain_q    = GAIN_RESET;
        smooth_q  = '0;
        primed_q  = 1'b0;
        sweep_col = COLX_W'(LEFT_X);
        last_col  = COLX_W'(LEFT_X);
        last_row  = ROWY_W'(TOP_Y + ROWS);
        range_q   = 2'd0;
        filter_q  = 1'b1;
        text_ph   = '0;
    endfunction

    function automatic void restart_sweep();
        sweep_col = COLX_W'(LEFT_X);
        last_col  = COLX_W'(LEFT_X);
        last_row  = row_for(smooth_q);
    endfunction

    function automatic void predict_trace(cmd_t c, logic [SAMPLE_W-1:0] smp);
        trace_res_t          r;
        logic [SMOOTH_W-1:0] samp_q;
        logic [63:0]         g;
        logic [63:0]         acc;
        logic [ROWY_W-1:0]   row;
        r      = '0;
        samp_q = {smp, {FRAC_W{1'b0}}};
        case (c)
            CMD_NONE: return;
            CMD_RANGE: begin
                range_q = (range_q == RANGE_LAST) ? 2'd0 : range_q + 2'd1;
                restart_sweep();
                r.restart = 1'b1;
            end
            CMD_FILTER: begin
                filter_q = !filter_q;
                smooth_q = samp_q;
                primed_q = 1'b1;
                restart_sweep();
                r.restart = 1'b1;
            end
            default: begin
                if (!primed_q) begin
                    smooth_q = samp_q;
                    last_row = row_for(smooth_q);
                    primed_q = 1'b1;
                end
                if (filter_q) begin
                    g   = (gain_q > GAIN_ONE) ? 64'd65536 : 64'(gain_q);
                    acc = 64'(smooth_q) * (64'd65536 - g) + 64'(samp_q) * g + 64'd32768;
                    smooth_q = SMOOTH_W'(acc >> 16);
                end else begin
                    smooth_q = samp_q;
                end
                row = row_for(smooth_q);
                if (sweep_col >= RIGHT_X) begin
                    sweep_col = COLX_W'(LEFT_X);
                    last_col  = COLX_W'(LEFT_X);
                    last_row  = row;
                    r.restart = 1'b1;
                end
                r.draw    = 1'b1;
                r.fx      = last_col;
                r.fy      = last_row;
                r.tx      = sweep_col;
                r.ty      = row;
                last_col  = sweep_col;
                last_row  = row;
                sweep_col = sweep_col + 1'b1;
                r.text    = (text_ph == 0);
                text_ph   = (text_ph == TEXT_PERIOD - 1) ? '0 : text_ph + 1'b1;
            end
        endcase
        r.shown = smooth_q[SMOOTH_W-1:FRAC_W];
        r.rng   = range_q;
        r.filt  = filter_q;
        trace_q.push_back(r);
    endfunction

    task automatic report_field(input string what, input int got, input int want);
        if (got != want) begin
            err_count++;
            if (err_count <= 40)
                $display("mismatch on result %0d: %s got %0d want %0d",
                         res_count, what, got, want);
        end
    endtask

    task automatic check_trace();
        trace_res_t want;
        if (trace_q.size() == 0) begin
            report_field("unexpected transfer", 1, 0);
        end else begin
            want = trace_q.pop_front();
            report_field("restart_frame", m_restart_frame, want.restart);
            report_field("draw_segment", m_draw_segment, want.draw);
            report_field("from_x", m_from_x, want.fx);
            report_field("from_y", m_from_y, want.fy);
            report_field("to_x", m_to_x, want.tx);
            report_field("to_y", m_to_y, want.ty);
            report_field("shown_value", m_shown_value, want.shown);
            report_field("range_now", m_range_now, want.rng);
            report_field("filter_now", m_filter_now, want.filt);
            report_field("text_refresh", m_text_refresh, want.text);
        end
        res_count++;
    endtask

    // result side with random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (m_valid && m_ready) begin
            check_trace();
            sink_draw = sink_idle ? $urandom_range(0, 18) : 0;
            stall_left <= sink_draw;
            m_ready    <= (sink_draw == 0);
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_left <= 0;
            m_ready    <= 1'b1;
        end
    end

    task automatic send_item(input cmd_t c, input logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = src_idle ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_cmd    <= c;
        s_sample <= smp;
        do @(posedge aclk); while (!s_ready);
        predict_trace(c, smp);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (trace_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] g);
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        gain_q = g;
        @(posedge aclk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return SAMPLE_W'($urandom_range(0, 63));
            3:       return SAMPLE_W'($urandom_range(4032, 4095));
            default: return SAMPLE_W'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic test_first_samples();
        send_item(CMD_SAMPLE, 12'd4095);
        send_item(CMD_SAMPLE, 12'd0);
        send_item(CMD_SAMPLE, 12'd4095);
        send_item(CMD_SAMPLE, 12'd2048);
    endtask

    task automatic test_key_commands();
        send_item(CMD_RANGE, 12'd0);
        send_item(CMD_SAMPLE, 12'd4095);
        send_item(CMD_SAMPLE, 12'd0);
        send_item(CMD_RANGE, 12'd4095);
        send_item(CMD_SAMPLE, 12'd2048);
        send_item(CMD_SAMPLE, 12'd4095);
        send_item(CMD_RANGE, 12'd1);
        send_item(CMD_SAMPLE, 12'd100);
        send_item(CMD_FILTER, 12'd4095);
        send_item(CMD_SAMPLE, 12'd0);
        send_item(CMD_SAMPLE, 12'd4095);
        send_item(CMD_NONE, 12'd4095);
        send_item(CMD_SAMPLE, 12'd1);
        send_item(CMD_FILTER, 12'd0);
        send_item(CMD_SAMPLE, 12'd3000);
    endtask

    task automatic test_gain_settings();
        logic [GAIN_W-1:0] gains[5];
        gains = '{GAIN_W'(0), GAIN_W'(1), GAIN_ONE, '1, GAIN_W'(32768)};
        foreach (gains[i]) begin
            wait_drained();
            write_gain(gains[i]);
            repeat (20) send_item(CMD_SAMPLE, pick_sample());
        end
        wait_drained();
        write_gain(GAIN_RESET);
    endtask

    // long enough run of samples to reach the right edge
    task automatic test_sweep_wrap();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        repeat (150) send_item(CMD_SAMPLE, pick_sample());
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        repeat (170) send_item(CMD_SAMPLE, pick_sample());
    endtask

    task automatic test_random_mix();
        int   k;
        cmd_t c;
        for (int n = 0; n < 420; n++) begin
            if (n % 100 == 99) begin
                wait_drained();
                write_gain(($urandom_range(0, 3) == 0) ? GAIN_W'($urandom_range(0, 131071))
                                                       : GAIN_W'($urandom_range(1, 65536)));
                src_idle  = ($urandom_range(0, 3) != 0);
                sink_idle = ($urandom_range(0, 3) != 0);
            end
            k = $urandom_range(0, 99);
            if (k < 90)
                c = CMD_SAMPLE;
            else if (k < 94)
                c = CMD_RANGE;
            else if (k < 97)
                c = CMD_FILTER;
            else
                c = CMD_NONE;
            send_item(c, pick_sample());
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    initial begin
        reset_trace();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_first_samples();
        test_key_commands();
        test_gain_settings();
        test_sweep_wrap();
        test_random_mix();
        wait_drained();

        if (err_count == 0)
            $display("[scope_trace_sweep_unit] OK");
        else
            $display("[scope_trace_sweep_unit] ERROR");
        $finish;
    end

endmodule
